/* src/bdc_pkg.sv */
// Shared types, constants and register codes for the bezel display compositor.
package bdc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COORD_W     = 10;
    localparam int DIM_W       = 11;
    localparam int CHAN_W      = 8;
    localparam int RGB_W       = 3 * CHAN_W;
    localparam int CFG_DATA_W  = RGB_W;
    localparam int CFG_INDEX_W = 3;

    localparam int IN_FIELDS_W = 2 * COORD_W + 7 * CHAN_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((RGB_W + 7) / 8) * 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BEZEL_ENABLE   = 3'd0,
        REG_SCREEN_LEFT    = 3'd1,
        REG_SCREEN_TOP     = 3'd2,
        REG_SCREEN_WIDTH   = 3'd3,
        REG_SCREEN_HEIGHT  = 3'd4,
        REG_BACKGROUND_RGB = 3'd5,
        REG_BRIGHTNESS     = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic               bezel_enable;
        logic [COORD_W-1:0] screen_left;
        logic [COORD_W-1:0] screen_top;
        logic [DIM_W-1:0]   screen_width;
        logic [DIM_W-1:0]   screen_height;
        logic [RGB_W-1:0]   background_rgb;
        logic [CHAN_W-1:0]  brightness;
    } bdc_cfg_t;

    // Members listed from the top bit down, so pos_x lands in the lowest bits.
    typedef struct packed {
        logic [CHAN_W-1:0]  frame_blue;
        logic [CHAN_W-1:0]  frame_green;
        logic [CHAN_W-1:0]  frame_red;
        logic [CHAN_W-1:0]  skin_alpha;
        logic [CHAN_W-1:0]  skin_blue;
        logic [CHAN_W-1:0]  skin_green;
        logic [CHAN_W-1:0]  skin_red;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_x;
    } pix_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_red;
    } pix_out_t;

endpackage

/* src/bdc_cfg_regs.sv */
// Configuration register file written through the plain write port.
module bdc_cfg_regs
    import bdc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output bdc_cfg_t               cfg
);

    bdc_cfg_t cfg_reg;
    bdc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            case (reg_index_t'(cfg_index))
                REG_BEZEL_ENABLE:   cfg_next.bezel_enable   = cfg_data[0];
                REG_SCREEN_LEFT:    cfg_next.screen_left    = cfg_data[COORD_W-1:0];
                REG_SCREEN_TOP:     cfg_next.screen_top     = cfg_data[COORD_W-1:0];
                REG_SCREEN_WIDTH:   cfg_next.screen_width   = cfg_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT:  cfg_next.screen_height  = cfg_data[DIM_W-1:0];
                REG_BACKGROUND_RGB: cfg_next.background_rgb = cfg_data[RGB_W-1:0];
                REG_BRIGHTNESS:     cfg_next.brightness     = cfg_data[CHAN_W-1:0];
                default:            cfg_next = cfg_reg;  // drop writes beyond the list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bezel_enable   <= 1'b1;
            cfg_reg.screen_left    <= '0;
            cfg_reg.screen_top     <= '0;
            cfg_reg.screen_width   <= DIM_W'(320);
            cfg_reg.screen_height  <= DIM_W'(480);
            cfg_reg.background_rgb <= '0;
            cfg_reg.brightness     <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/bdc_pixel_core.sv */
// Per-pixel datapath: screen rectangle test, brightness scale and skin blend.
module bdc_pixel_core
    import bdc_pkg::*;
(
    input  bdc_cfg_t cfg,
    input  pix_in_t  pix,
    output pix_out_t result
);

    // Exact n/255 for n < 255*256: (n + (n >> 8) + 1) >> 8.
    function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] n);
        logic [2*CHAN_W:0] sum;
        sum = (2*CHAN_W+1)'(n) + (2*CHAN_W+1)'(n[2*CHAN_W-1:CHAN_W]) + (2*CHAN_W+1)'(1);
        return sum[2*CHAN_W-1:CHAN_W];
    endfunction

    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
                                                     input logic [CHAN_W-1:0] level);
        logic [2*CHAN_W-1:0] prod;
        prod = c * level;
        return div255(prod + (2*CHAN_W)'(127));
    endfunction

    // Opaque and transparent skin fall out of the formula exactly.
    function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] p,
                                                     input logic [CHAN_W-1:0] a,
                                                     input logic [CHAN_W-1:0] bg);
        logic [2*CHAN_W-1:0] fore;
        logic [2*CHAN_W-1:0] back;
        logic [CHAN_W-1:0]   inv_a;
        // 255 - a, kept at channel width before the multiply
        inv_a = ~a;
        fore = p * a;
        back = bg * inv_a;
        return div255(fore + back);
    endfunction

    logic [DIM_W-1:0]   win_w;
    logic [DIM_W-1:0]   win_h;
    logic [COORD_W+1:0] right_edge;
    logic [COORD_W+1:0] bottom_edge;
    logic               in_screen;
    pix_out_t           scaled;
    pix_out_t           blended;

    always_comb
    begin
        win_w = (32'(cfg.screen_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cfg.screen_width;
        win_h = (32'(cfg.screen_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT)
                                                       : cfg.screen_height;
        right_edge  = (COORD_W+2)'(cfg.screen_left) + (COORD_W+2)'(win_w);
        bottom_edge = (COORD_W+2)'(cfg.screen_top) + (COORD_W+2)'(win_h);
        in_screen = (pix.pos_x >= cfg.screen_left) &&
                    ((COORD_W+2)'(pix.pos_x) < right_edge) &&
                    (pix.pos_y >= cfg.screen_top) &&
                    ((COORD_W+2)'(pix.pos_y) < bottom_edge);

        scaled.out_red   = scale_chan(pix.frame_red, cfg.brightness);
        scaled.out_green = scale_chan(pix.frame_green, cfg.brightness);
        scaled.out_blue  = scale_chan(pix.frame_blue, cfg.brightness);

        blended.out_red   = blend_chan(pix.skin_red, pix.skin_alpha,
                                       cfg.background_rgb[3*CHAN_W-1:2*CHAN_W]);
        blended.out_green = blend_chan(pix.skin_green, pix.skin_alpha,
                                       cfg.background_rgb[2*CHAN_W-1:CHAN_W]);
        blended.out_blue  = blend_chan(pix.skin_blue, pix.skin_alpha,
                                       cfg.background_rgb[CHAN_W-1:0]);

        result = (!cfg.bezel_enable || in_screen) ? scaled : blended;
    end

endmodule

/* src/bezel_display_compositor.sv */
// Top level of the bezel display compositor: input stage, pixel datapath, output stage.
//
//  channel   | group      | payload (low bit first)
//  ----------+------------+----------------------------------------------------
//  pixel in  | s_axis_*   | pos_x, pos_y, skin r/g/b/alpha, frame r/g/b, 4 pad
//  pixel out | m_axis_*   | out_red, out_green, out_blue
//  config    | cfg_*      | write enable, register index, data (no read-back)
//
// One pixel per clock while the output is ready; pix_reg feeds the datapath into out_reg.
// The rate is set by the single registered pass through three 8x8 multiplies per channel.
// Reset clears both stage valid flags and loads the register defaults.
// A stalled output holds its result and the input stage; the input side keeps taking
// pixels as long as either stage has room.
module bezel_display_compositor
    import bdc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // pos_x, pos_y, skin_red, skin_green,
                                                   // skin_blue, skin_alpha, frame_red,
                                                   // frame_green, frame_blue, zero pad
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // out_red, out_green, out_blue
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    bdc_cfg_t cfg;
    pix_in_t  pix_reg;
    pix_out_t result;
    pix_out_t out_reg;
    logic     pix_valid_reg;
    logic     pix_valid_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     load_out;
    logic     in_xfer;

    bdc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bdc_pixel_core u_pixel_core (
        .cfg    (cfg),
        .pix    (pix_reg),
        .result (result)
    );

    always_comb
    begin
        load_out       = !out_valid_reg || m_axis_tready;
        s_axis_tready  = !pix_valid_reg || load_out;
        in_xfer        = s_axis_tvalid && s_axis_tready;
        pix_valid_next = s_axis_tready ? s_axis_tvalid : pix_valid_reg;
        out_valid_next = load_out ? pix_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pix_reg <= pix_in_t'(s_axis_tdata[IN_FIELDS_W-1:0]);
        end
        if (load_out && pix_valid_reg)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_reg);

`ifndef NO_ASSERTIONS
    // A held input stage keeps its pixel until the output stage frees up.
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid_reg && !load_out |=> pix_valid_reg && $stable(pix_reg))
        else $error("input stage lost or changed a pixel while stalled");

    // An input transfer always fills the input stage.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> pix_valid_reg)
        else $error("accepted pixel did not reach the input stage");

    // A pixel moved out of the input stage shows up as a result.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid_reg && load_out |=> m_axis_tvalid)
        else $error("advanced pixel produced no result");

    // Bezel off at full brightness passes the framebuffer red channel untouched.
    a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid_reg && load_out && !cfg.bezel_enable && (cfg.brightness == 8'hFF)
        |=> m_axis_tdata[CHAN_W-1:0] == $past(pix_reg.frame_red))
        else $error("full-brightness passthrough altered the red channel");
`endif

endmodule

/* sim/bezel_display_compositor_tb.sv */
// Self-checking testbench for the bezel display compositor pixel stream.
`timescale 1ns / 100ps

module bezel_display_compositor_tb;
    import bdc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PIXELS_PER_PHASE = 90;
    localparam int RANDOM_PHASES = 8;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // pos_x, pos_y, skin r/g/b/alpha,
                                                 // frame r/g/b, zero pad
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;        // out_red, out_green, out_blue
    logic                   cfg_wen = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    bdc_cfg_t display_cfg;
    pix_out_t expected_pixels[$];
    int       error_count = 0;
    int       idle_cycles = 0;
    bit       src_steady = 1'b0;
    bit       sink_steady = 1'b0;

    bezel_display_compositor DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------- prediction

    function automatic logic [CHAN_W-1:0] backlight_scale(input logic [CHAN_W-1:0] c);
        int v;
        v = (int'(c) * int'(display_cfg.brightness) + 127) / 255;
        return v[CHAN_W-1:0];
    endfunction

    function automatic logic [CHAN_W-1:0] blend_over_background(
        input logic [CHAN_W-1:0] c,
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] bg
    );
        int v;
        if (a == 8'd255)
            return c;
        if (a == 8'd0)
            return bg;
        v = (int'(c) * int'(a) + int'(bg) * (255 - int'(a))) / 255;
        return v[CHAN_W-1:0];
    endfunction

    function automatic pix_out_t composite_pixel(input pix_in_t p);
        pix_out_t o;
        int       w;
        int       h;
        int       left;
        int       top;
        bit       in_screen;
        logic [RGB_W-1:0] bg;
        w = (int'(display_cfg.screen_width) > MAX_WIDTH) ? MAX_WIDTH
                                                           : int'(display_cfg.screen_width);
        h = (int'(display_cfg.screen_height) > MAX_HEIGHT) ? MAX_HEIGHT
                                                             : int'(display_cfg.screen_height);
        left = int'(display_cfg.screen_left);
        top = int'(display_cfg.screen_top);
        bg = display_cfg.background_rgb;
        in_screen = (int'(p.pos_x) >= left) && (int'(p.pos_x) < left + w) &&
                    (int'(p.pos_y) >= top) && (int'(p.pos_y) < top + h);
        if (!display_cfg.bezel_enable || in_screen)
        begin
            o.out_red = backlight_scale(p.frame_red);
            o.out_green = backlight_scale(p.frame_green);
            o.out_blue = backlight_scale(p.frame_blue);
        end
        else
        begin
            o.out_red = blend_over_background(p.skin_red, p.skin_alpha, bg[23:16]);
            o.out_green = blend_over_background(p.skin_green, p.skin_alpha, bg[15:8]);
            o.out_blue = blend_over_background(p.skin_blue, p.skin_alpha, bg[7:0]);
        end
        return o;
    endfunction

    function automatic void apply_reg_write(
        input logic [CFG_INDEX_W-1:0] idx,
        input logic [CFG_DATA_W-1:0]  data
    );
        case (idx)
            REG_BEZEL_ENABLE:   display_cfg.bezel_enable = data[0];
            REG_SCREEN_LEFT:    display_cfg.screen_left = data[COORD_W-1:0];
            REG_SCREEN_TOP:     display_cfg.screen_top = data[COORD_W-1:0];
            REG_SCREEN_WIDTH:   display_cfg.screen_width = data[DIM_W-1:0];
            REG_SCREEN_HEIGHT:  display_cfg.screen_height = data[DIM_W-1:0];
            REG_BACKGROUND_RGB: display_cfg.background_rgb = data[RGB_W-1:0];
            REG_BRIGHTNESS:     display_cfg.brightness = data[CHAN_W-1:0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic pix_in_t random_pixel();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return pix_in_t'(bits[IN_FIELDS_W-1:0]);
    endfunction

    function automatic pix_in_t make_pixel(
        input int x, input int y,
        input int sr, input int sg, input int sb, input int sa,
        input int fr, input int fg, input int fb
    );
        pix_in_t p;
        p.pos_x = x[COORD_W-1:0];
        p.pos_y = y[COORD_W-1:0];
        p.skin_red = sr[CHAN_W-1:0];
        p.skin_green = sg[CHAN_W-1:0];
        p.skin_blue = sb[CHAN_W-1:0];
        p.skin_alpha = sa[CHAN_W-1:0];
        p.frame_red = fr[CHAN_W-1:0];
        p.frame_green = fg[CHAN_W-1:0];
        p.frame_blue = fb[CHAN_W-1:0];
        return p;
    endfunction

    function automatic int pick_extreme(input int lo, input int hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return int'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic int pick_dimension();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return int'($urandom_range(MAX_WIDTH + 1, 2047));
            2: return MAX_WIDTH;
            3: return 1;
            default: return int'($urandom_range(1, MAX_WIDTH));
        endcase
    endfunction

    // Aim at a rectangle edge so both sides of the boundary get hit.
    function automatic logic [COORD_W-1:0] coord_near(input int lo, input int span,
                                                      input int cap);
        int base;
        if (span > cap)
            span = cap;
        case ($urandom_range(0, 2))
            0: base = lo;
            1: base = lo + span;
            default: base = int'($urandom_range(0, 1023));
        endcase
        base = base + int'($urandom_range(0, 4)) - 2;
        return base[COORD_W-1:0];
    endfunction

    // Fill the bits above the register width with noise; the block must drop them.
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                        input int bits);
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] d;
        mask = (bits >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << bits) - 1'b1);
        d = CFG_DATA_W'($urandom);
        return (d & ~mask) | (v & mask);
    endfunction

    // ---------------------------------------------------------------- transfers

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_wen <= 1'b0;
        apply_reg_write(idx, data);
    endtask

    task automatic configure(
        input logic               en,
        input logic [COORD_W-1:0] left,
        input logic [COORD_W-1:0] top,
        input logic [DIM_W-1:0]   w,
        input logic [DIM_W-1:0]   h,
        input logic [RGB_W-1:0]   bg,
        input logic [CHAN_W-1:0]  br,
        input bit                 noisy
    );
        write_reg(REG_BEZEL_ENABLE,
                  noisy ? with_junk(CFG_DATA_W'(en), 1) : CFG_DATA_W'(en));
        write_reg(REG_SCREEN_LEFT,
                  noisy ? with_junk(CFG_DATA_W'(left), COORD_W) : CFG_DATA_W'(left));
        write_reg(REG_SCREEN_TOP,
                  noisy ? with_junk(CFG_DATA_W'(top), COORD_W) : CFG_DATA_W'(top));
        write_reg(REG_SCREEN_WIDTH,
                  noisy ? with_junk(CFG_DATA_W'(w), DIM_W) : CFG_DATA_W'(w));
        write_reg(REG_SCREEN_HEIGHT,
                  noisy ? with_junk(CFG_DATA_W'(h), DIM_W) : CFG_DATA_W'(h));
        write_reg(REG_BACKGROUND_RGB, bg);
        write_reg(REG_BRIGHTNESS,
                  noisy ? with_junk(CFG_DATA_W'(br), CHAN_W) : CFG_DATA_W'(br));
    endtask

    task automatic send_pixel(input pix_in_t p);
        int gap;
        gap = src_steady ? 0 : int'($urandom_range(0, 11));
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, p};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_pixels.push_back(composite_pixel(p));
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_state();
        send_pixel(make_pixel(0, 0, 12, 34, 56, 200, 255, 128, 1));
        send_pixel(make_pixel(319, 479, 12, 34, 56, 0, 0, 77, 254));
        send_pixel(make_pixel(320, 479, 255, 0, 170, 255, 9, 9, 9));
        send_pixel(make_pixel(319, 480, 255, 255, 255, 0, 9, 9, 9));
    endtask

    task automatic test_rectangle_edges();
        int xs[7] = '{99, 100, 299, 300, 100, 100, 100};
        int ys[7] = '{50, 50, 149, 149, 149, 150, 49};
        pix_in_t p;
        configure(1'b1, 10'd100, 10'd50, 11'd200, 11'd100, 24'hA55AC3, 8'd128, 1'b0);
        for (int i = 0; i < 7; i++)
        begin
            p = random_pixel();
            p.pos_x = xs[i][COORD_W-1:0];
            p.pos_y = ys[i][COORD_W-1:0];
            p.skin_alpha = 8'd128;
            send_pixel(p);
        end
    endtask

    task automatic test_alpha_extremes();
        configure(1'b1, 10'd100, 10'd50, 11'd200, 11'd100, 24'hFFFFFF, 8'd255, 1'b0);
        send_pixel(make_pixel(0, 0, 255, 255, 255, 0, 1, 2, 3));
        send_pixel(make_pixel(1023, 1023, 0, 0, 0, 255, 1, 2, 3));
        send_pixel(make_pixel(0, 1023, 255, 255, 255, 1, 1, 2, 3));
        send_pixel(make_pixel(1023, 0, 0, 0, 0, 254, 1, 2, 3));
    endtask

    task automatic test_brightness_extremes();
        configure(1'b1, 10'd0, 10'd0, 11'd1024, 11'd1024, 24'h000000, 8'd0, 1'b0);
        send_pixel(make_pixel(512, 512, 0, 0, 0, 0, 255, 255, 255));
        write_reg(REG_BRIGHTNESS, CFG_DATA_W'(1));
        send_pixel(make_pixel(1023, 1023, 0, 0, 0, 0, 255, 128, 127));
    endtask

    task automatic test_empty_rectangle();
        configure(1'b1, 10'd0, 10'd0, 11'd0, 11'd480, 24'h3C7E81, 8'd255, 1'b0);
        send_pixel(make_pixel(0, 0, 200, 100, 50, 77, 255, 255, 255));
        configure(1'b1, 10'd0, 10'd0, 11'd320, 11'd0, 24'h3C7E81, 8'd255, 1'b0);
        send_pixel(make_pixel(0, 0, 200, 100, 50, 177, 255, 255, 255));
    endtask

    task automatic test_oversize_rectangle();
        configure(1'b1, 10'd0, 10'd0, 11'd2047, 11'd2047, 24'h102030, 8'd200, 1'b0);
        send_pixel(make_pixel(1023, 1023, 1, 2, 3, 128, 250, 5, 99));
        configure(1'b1, 10'd1023, 10'd1023, 11'd1, 11'd1, 24'h102030, 8'd200, 1'b0);
        send_pixel(make_pixel(1023, 1023, 1, 2, 3, 128, 250, 5, 99));
        send_pixel(make_pixel(1022, 1023, 1, 2, 3, 128, 250, 5, 99));
    endtask

    task automatic test_bezel_disabled();
        configure(1'b0, 10'd1023, 10'd1023, 11'd1, 11'd1, 24'hFFFFFF, 8'd200, 1'b0);
        send_pixel(make_pixel(0, 0, 255, 255, 255, 255, 10, 128, 255));
    endtask

    task automatic test_unused_index();
        configure(1'b1, 10'd0, 10'd0, 11'd0, 11'd0, 24'h123456, 8'd255, 1'b0);
        write_reg(REG_INDEX_UNUSED, 24'hFFFFFF);
        send_pixel(make_pixel(5, 5, 255, 255, 255, 0, 255, 255, 255));
    endtask

    task automatic test_random_frames();
        pix_in_t p;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            configure(($urandom_range(0, 4) != 0), COORD_W'(pick_extreme(0, 1023)),
                      COORD_W'(pick_extreme(0, 1023)), DIM_W'(pick_dimension()),
                      DIM_W'(pick_dimension()), RGB_W'(pick_extreme(0, 24'hFFFFFF)),
                      CHAN_W'(pick_extreme(0, 255)), 1'b1);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_INDEX_UNUSED, CFG_DATA_W'($urandom));
            for (int k = 0; k < PIXELS_PER_PHASE; k++)
            begin
                // switch between gapped and back-to-back input stretches
                if (k % 30 == 0)
                    src_steady = ($urandom_range(0, 3) == 0);
                p = random_pixel();
                if ($urandom_range(0, 3) != 0)
                    p.pos_x = coord_near(int'(display_cfg.screen_left),
                                         int'(display_cfg.screen_width), MAX_WIDTH);
                if ($urandom_range(0, 3) != 0)
                    p.pos_y = coord_near(int'(display_cfg.screen_top),
                                         int'(display_cfg.screen_height), MAX_HEIGHT);
                case ($urandom_range(0, 3))
                    0: p.skin_alpha = '0;
                    1: p.skin_alpha = '1;
                    default: ;
                endcase
                send_pixel(p);
            end
        end
        src_steady = 1'b0;
    endtask

    // ---------------------------------------------------------------- output side

    initial
    begin
        int       stall;
        pix_out_t got;
        pix_out_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = sink_steady ? 0 : int'($urandom_range(0, 11));
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got = pix_out_t'(m_axis_tdata[RGB_W-1:0]);
            if (expected_pixels.size() == 0)
            begin
                $error("output pixel transfer with nothing expected: %h", got);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got.out_red !== want.out_red)
                begin
                    $error("out_red expected %0d, actual %0d", want.out_red, got.out_red);
                    error_count++;
                end
                if (got.out_green !== want.out_green)
                begin
                    $error("out_green expected %0d, actual %0d", want.out_green, got.out_green);
                    error_count++;
                end
                if (got.out_blue !== want.out_blue)
                begin
                    $error("out_blue expected %0d, actual %0d", want.out_blue, got.out_blue);
                    error_count++;
                end
            end
            if ($urandom_range(0, 29) == 0)
                sink_steady = !sink_steady;
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk)
    begin
        if (!rst_n || cfg_wen || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        display_cfg.bezel_enable = 1'b1;
        display_cfg.screen_left = '0;
        display_cfg.screen_top = '0;
        display_cfg.screen_width = 11'd320;
        display_cfg.screen_height = 11'd480;
        display_cfg.background_rgb = '0;
        display_cfg.brightness = 8'd255;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_rectangle_edges();
        test_alpha_extremes();
        test_brightness_extremes();
        test_empty_rectangle();
        test_oversize_rectangle();
        test_bezel_disabled();
        test_unused_index();
        test_random_frames();

        // drain, then give the pipeline time to show any stray output
        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* bezel_display_compositor.f */
src/bdc_pkg.sv
src/bdc_cfg_regs.sv
src/bdc_pixel_core.sv
src/bezel_display_compositor.sv
sim/bezel_display_compositor_tb.sv
